@@ src/bpfa_pkg.sv @@
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared sizes, codes and types of the bitmap page frame allocator.
// ----------------------------------------------------------------------------
package bpfa_pkg;

  localparam int NUM_FRAMES = 65536;
  localparam int WORD_BITS  = 64;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int BYTES      = WORD_BITS / 8;
  localparam int MAP_WORDS  = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  // A frame index below NUM_FRAMES, and a bound up to NUM_FRAMES itself.
  localparam int FR_W       = $clog2(NUM_FRAMES);
  localparam int HI_W       = $clog2(NUM_FRAMES + 1);
  localparam int FCNT_W     = HI_W;
  localparam logic [52:0] NUM_FRAMES_X = 53'(NUM_FRAMES);

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_REGION = 2'd1;
  localparam logic [1:0] MODE_ALLOC  = 2'd2;
  localparam logic [1:0] MODE_FREE   = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOFREE  = 3'd1;
  localparam logic [2:0] ST_RANGE   = 3'd2;
  localparam logic [2:0] ST_ZERO    = 3'd3;
  localparam logic [2:0] ST_ALREADY = 3'd4;

  localparam logic REG_TYPE_MASK = 1'b0;
  localparam logic REG_RSV_BELOW = 1'b1;

  typedef enum logic {
    WU_SET,
    WU_TAKE
  } wu_op_t;

  typedef struct packed {
    logic [15:0] type_mask;
    logic [16:0] rsv_below;
  } cfg_t;

  typedef struct packed {
    logic [WORD_BITS-1:0]  wdata;
    logic                  found;
    logic [BIT_W-1:0]      first;
    logic [BYTES-1:0][3:0] bcnt;
  } wu_res_t;

  function automatic logic [WA_W-1:0] word_of(input logic [FR_W-1:0] f);
    logic [FR_W-1:0] s;
    s = f >> BIT_W;
    return s[WA_W-1:0];
  endfunction

endpackage

@@ src/bpfa_ram.sv @@
// ----------------------------------------------------------------------------
// bpfa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bpfa_ram #(
  parameter  int WIDTH = 64,
  parameter  int DEPTH = 1024,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/bpfa_word_unit.sv @@
// ----------------------------------------------------------------------------
// bpfa_word_unit
// Shared map word unit: sets a bit range or takes the lowest free bit.
// ----------------------------------------------------------------------------
module bpfa_word_unit import bpfa_pkg::*; (
  input  wu_op_t               op,
  input  logic [WORD_BITS-1:0] word,
  input  logic [BIT_W-1:0]     lo_b,
  input  logic [BIT_W-1:0]     hi_b,
  output wu_res_t              res
);

  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] newbits;
  logic [WORD_BITS-1:0] lowest;
  logic [BIT_W-1:0]     idx;

  function automatic logic [3:0] pop8(input logic [7:0] b);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < 8; i++) begin
      c = c + 4'(b[i]);
    end
    return c;
  endfunction

  always_comb begin
    mask    = ({WORD_BITS{1'b1}} << lo_b) & ({WORD_BITS{1'b1}} >> (~hi_b));
    newbits = mask & ~word;
    // Two's complement trick isolates the lowest set bit as a one-hot word.
    lowest  = word & (~word + WORD_BITS'(1));
    idx     = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (lowest[i]) begin
        idx = idx | BIT_W'(i);
      end
    end
    res.first = idx;
    case (op)
      WU_SET: begin
        res.wdata = word | mask;
        res.found = |newbits;
      end
      WU_TAKE: begin
        res.wdata = word & ~lowest;
        res.found = |word;
      end
      default: begin
        res.wdata = word;
        res.found = 1'b0;
      end
    endcase
    for (int k = 0; k < BYTES; k++) begin
      res.bcnt[k] = (op == WU_SET) ? pop8(newbits[8*k +: 8]) : 4'd0;
    end
  end

endmodule

@@ src/bpfa_cfg.sv @@
// ----------------------------------------------------------------------------
// bpfa_cfg
// Register file for the usable type mask and the reserve limit.
// ----------------------------------------------------------------------------
module bpfa_cfg import bpfa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [15:0] type_mask_r;
  logic [16:0] rsv_below_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_mask_r <= 16'd224;
      rsv_below_r <= 17'd256;
    end else if (wr_en) begin
      case (paddr[2])
        REG_TYPE_MASK: type_mask_r <= pwdata[15:0];
        REG_RSV_BELOW: rsv_below_r <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TYPE_MASK: prdata = {16'd0, type_mask_r};
      REG_RSV_BELOW: prdata = {15'd0, rsv_below_r};
      default:       prdata = '0;
    endcase
  end

  assign cfg.type_mask = type_mask_r;
  assign cfg.rsv_below = rsv_below_r;

endmodule

@@ src/bitmap_page_frame_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator
// First-fit page frame allocator over a one-bit-per-frame free map.
// ----------------------------------------------------------------------------
// Channel  Direction  Signals                          Contents
// in       slave      in_tvalid/in_tready/in_tdata     region and frame fields
//                     in_tuser                         mode
// out      master     out_tvalid/out_tready/out_tdata  status and counters
// cfg      APB slave  cfg_psel .. cfg_pready           type mask, reserve limit
//
// The free map is a RAM of MAP_WORDS 64-bit words that one word unit reads,
// modifies and writes a word at a time. Add region steps through R1 to R5,
// then reads, evaluates and counts each covered word (ends after R1 for an
// unusable type, after R3 for one that misses the map); allocate reads and
// evaluates words up to the first with a free frame; free checks the frame,
// then reads, evaluates and counts its word; clear zeroes every word. Each
// then loads its result. After reset all words are cleared with in_tready
// low. A result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator import bpfa_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // region_type[3:0], region_start_frame[55:4], region_frame_count[107:56],
  // release_frame[159:108]
  input  logic [159:0] in_tdata,
  // mode[1:0]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[2:0], granted_frame[18:3], free_total[35:19], reserved_total[67:36],
  // highest_end_frame[120:68], zero[127:121]
  output logic [127:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLR, S_R1, S_R2, S_R3, S_R4, S_R5,
    S_F1, S_RD, S_EV, S_CNT, S_DONE
  } state_t;

  cfg_t    cfg;
  wu_res_t wu;

  state_t          state_r, state_nxt;
  logic [WA_W-1:0] word_r, word_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [127:0]    out_data_r, out_data_nxt;
  logic [FCNT_W-1:0] free_cnt_r, free_cnt_nxt;
  logic [31:0]     rsv_r, rsv_nxt;
  logic [52:0]     max_end_r, max_end_nxt;

  logic [1:0]      mode_r, mode_nxt;
  logic [3:0]      type_r, type_nxt;
  logic [51:0]     start_r, start_nxt;
  logic [51:0]     count_r, count_nxt;
  logic [51:0]     release_r, release_nxt;
  logic [2:0]      status_r, status_nxt;
  logic [15:0]     granted_r, granted_nxt;
  wu_op_t          op_r, op_nxt;
  logic [52:0]     end_r, end_nxt;
  logic [HI_W-1:0] hi_r, hi_nxt;
  logic [HI_W-1:0] rhi_r, rhi_nxt;
  logic [52:0]     lo_full_r, lo_full_nxt;
  logic [HI_W-1:0] res_d_r, res_d_nxt;
  logic            walk_r, walk_nxt;
  logic [FR_W-1:0] lo_r, lo_nxt;
  logic [FR_W-1:0] hm1_r, hm1_nxt;
  logic [BYTES-1:0][3:0] bcnt_r, bcnt_nxt;

  logic            ram_we;
  logic            ram_re;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [BIT_W-1:0] lo_b;
  logic [BIT_W-1:0] hi_b;
  logic            last_word;

  logic [52:0]     hi_x;
  logic [52:0]     rbf_x;
  logic [52:0]     start_x;
  logic [HI_W-1:0] hm1;
  logic [32:0]     rsv_sum;
  logic [6:0]      add_cnt;
  logic [WA_W+BIT_W-1:0]  fidx;
  logic [WA_W+BIT_W+15:0] fidx_x;
  logic [FCNT_W+16:0]     free_x;

  bpfa_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  bpfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (word_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (word_r),
    .rdata (ram_rdata)
  );

  assign lo_b = (word_r == word_of(lo_r)) ? lo_r[BIT_W-1:0] : '0;
  assign hi_b = (word_r == word_of(hm1_r)) ? hm1_r[BIT_W-1:0] : '1;

  bpfa_word_unit u_wu (
    .op   (op_r),
    .word (ram_rdata),
    .lo_b (lo_b),
    .hi_b (hi_b),
    .res  (wu)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign last_word  = (word_r == WA_W'(MAP_WORDS - 1));
  assign hi_x       = 53'(hi_r);
  assign rbf_x      = 53'(cfg.rsv_below);
  assign start_x    = {1'b0, start_r};
  assign hm1        = hi_r - HI_W'(1);
  assign rsv_sum    = {1'b0, rsv_r} + 33'(res_d_r);
  assign fidx       = {word_r, wu.first};
  assign fidx_x     = {16'd0, fidx};
  assign free_x     = {17'd0, free_cnt_r};

  always_comb begin
    add_cnt = '0;
    for (int k = 0; k < BYTES; k++) begin
      add_cnt = add_cnt + 7'(bcnt_r[k]);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    word_nxt      = word_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    free_cnt_nxt  = free_cnt_r;
    rsv_nxt       = rsv_r;
    max_end_nxt   = max_end_r;
    mode_nxt      = mode_r;
    type_nxt      = type_r;
    start_nxt     = start_r;
    count_nxt     = count_r;
    release_nxt   = release_r;
    status_nxt    = status_r;
    granted_nxt   = granted_r;
    op_nxt        = op_r;
    end_nxt       = end_r;
    hi_nxt        = hi_r;
    rhi_nxt       = rhi_r;
    lo_full_nxt   = lo_full_r;
    res_d_nxt     = res_d_r;
    walk_nxt      = walk_r;
    lo_nxt        = lo_r;
    hm1_nxt       = hm1_r;
    bcnt_nxt      = bcnt_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_wdata     = wu.wdata;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        if (last_word) begin
          state_nxt = S_IDLE;
        end else begin
          word_nxt = word_r + WA_W'(1);
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt    = in_tuser;
          type_nxt    = in_tdata[3:0];
          start_nxt   = in_tdata[55:4];
          count_nxt   = in_tdata[107:56];
          release_nxt = in_tdata[159:108];
          status_nxt  = ST_OK;
          granted_nxt = '0;
          word_nxt    = '0;
          case (in_tuser)
            MODE_CLEAR:  state_nxt = S_CLR;
            MODE_REGION: state_nxt = S_R1;
            MODE_ALLOC: begin
              status_nxt = ST_NOFREE;
              op_nxt     = WU_TAKE;
              state_nxt  = S_RD;
            end
            MODE_FREE:   state_nxt = S_F1;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_CLR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        if (last_word) begin
          free_cnt_nxt = '0;
          rsv_nxt      = '0;
          max_end_nxt  = '0;
          state_nxt    = S_DONE;
        end else begin
          word_nxt = word_r + WA_W'(1);
        end
      end
      S_R1: begin
        if (!cfg.type_mask[type_r]) begin
          state_nxt = S_DONE;
        end else begin
          end_nxt   = {1'b0, start_r} + {1'b0, count_r};
          state_nxt = S_R2;
        end
      end
      S_R2: begin
        if (end_r > max_end_r) begin
          max_end_nxt = end_r;
        end
        hi_nxt    = (end_r < NUM_FRAMES_X) ? end_r[HI_W-1:0] : HI_W'(NUM_FRAMES);
        state_nxt = S_R3;
      end
      S_R3: begin
        if (start_x >= hi_x) begin
          state_nxt = S_DONE;
        end else begin
          // The lower of the two always fits the bound's width.
          rhi_nxt     = (hi_x < rbf_x) ? hi_r : rbf_x[HI_W-1:0];
          lo_full_nxt = (start_x > rbf_x) ? start_x : rbf_x;
          state_nxt   = S_R4;
        end
      end
      S_R4: begin
        res_d_nxt = (start_x < 53'(rhi_r)) ? (rhi_r - start_r[HI_W-1:0]) : '0;
        walk_nxt  = (lo_full_r < hi_x);
        lo_nxt    = lo_full_r[FR_W-1:0];
        hm1_nxt   = hm1[FR_W-1:0];
        state_nxt = S_R5;
      end
      S_R5: begin
        rsv_nxt = rsv_sum[32] ? 32'hFFFF_FFFF : rsv_sum[31:0];
        if (walk_r) begin
          word_nxt  = word_of(lo_r);
          op_nxt    = WU_SET;
          state_nxt = S_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_F1: begin
        if (release_r == '0) begin
          status_nxt = ST_ZERO;
          state_nxt  = S_DONE;
        end else if ({1'b0, release_r} >= NUM_FRAMES_X) begin
          status_nxt = ST_RANGE;
          state_nxt  = S_DONE;
        end else begin
          lo_nxt    = release_r[FR_W-1:0];
          hm1_nxt   = release_r[FR_W-1:0];
          word_nxt  = word_of(release_r[FR_W-1:0]);
          op_nxt    = WU_SET;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_EV;
      end
      S_EV: begin
        case (op_r)
          WU_SET: begin
            ram_we   = 1'b1;
            bcnt_nxt = wu.bcnt;
            if (mode_r == MODE_FREE && !wu.found) begin
              status_nxt = ST_ALREADY;
            end
            state_nxt = S_CNT;
          end
          WU_TAKE: begin
            if (wu.found) begin
              // The scan stops at the first nonzero word either way.
              if (53'(fidx) < NUM_FRAMES_X) begin
                ram_we      = 1'b1;
                granted_nxt = fidx_x[15:0];
                status_nxt  = ST_OK;
                if (free_cnt_r != '0) begin
                  free_cnt_nxt = free_cnt_r - FCNT_W'(1);
                end
              end
              state_nxt = S_DONE;
            end else if (last_word) begin
              state_nxt = S_DONE;
            end else begin
              word_nxt  = word_r + WA_W'(1);
              state_nxt = S_RD;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_CNT: begin
        free_cnt_nxt = free_cnt_r + FCNT_W'(add_cnt);
        if (mode_r == MODE_REGION && word_r != word_of(hm1_r)) begin
          word_nxt  = word_r + WA_W'(1);
          state_nxt = S_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {7'd0, max_end_r, rsv_r, free_x[16:0], granted_r, status_r};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      word_r      <= '0;
      out_valid_r <= 1'b0;
      free_cnt_r  <= '0;
      rsv_r       <= '0;
      max_end_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      word_r      <= word_nxt;
      out_valid_r <= out_valid_nxt;
      free_cnt_r  <= free_cnt_nxt;
      rsv_r       <= rsv_nxt;
      max_end_r   <= max_end_nxt;
    end
    out_data_r <= out_data_nxt;
    mode_r     <= mode_nxt;
    type_r     <= type_nxt;
    start_r    <= start_nxt;
    count_r    <= count_nxt;
    release_r  <= release_nxt;
    status_r   <= status_nxt;
    granted_r  <= granted_nxt;
    op_r       <= op_nxt;
    end_r      <= end_nxt;
    hi_r       <= hi_nxt;
    rhi_r      <= rhi_nxt;
    lo_full_r  <= lo_full_nxt;
    res_d_r    <= res_d_nxt;
    walk_r     <= walk_nxt;
    lo_r       <= lo_nxt;
    hm1_r      <= hm1_nxt;
    bcnt_r     <= bcnt_nxt;
  end

endmodule

@@ src/bpfa_checker.sv @@
// ----------------------------------------------------------------------------
// bpfa_port_checks
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bpfa_port_checks import bpfa_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata
);

  logic [2:0]  status;
  logic [15:0] granted;
  logic [16:0] free_total;

  assign status     = out_tdata[2:0];
  assign granted    = out_tdata[18:3];
  assign free_total = out_tdata[35:19];

  // A waiting result holds still until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Every accepted item drops in_tready in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after an accepted item");

  // Only a successful allocation reports a frame.
  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status != ST_OK |-> granted == '0)
    else $error("frame granted with a failing status");

  // An empty map must agree with the free count.
  a_nofree_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status == ST_NOFREE |-> free_total == '0)
    else $error("no free frame reported with a nonzero free count");

endmodule

bind bitmap_page_frame_allocator bpfa_port_checks u_bpfa_port_checks (.*);

@@ sim/bpfa_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfa_checker
// Watches the item, result and register ports of the page frame allocator.
// It keeps its own free map, counters and register copies, works out the
// result of every accepted item and compares each delivered result with the
// oldest one still awaited.
// ----------------------------------------------------------------------------
module bpfa_checker import bpfa_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [159:0] in_tdata,
  input  logic [1:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [127:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic         cfg_pready,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output int           mismatches,
  output int           replies_due
);

  localparam logic [2:0]  ADDR_TYPE_MASK = {REG_TYPE_MASK, 2'b00};
  localparam logic [2:0]  ADDR_RSV_BELOW = {REG_RSV_BELOW, 2'b00};
  localparam logic [15:0] MASK_AT_RESET  = 16'd224;
  localparam logic [16:0] RSV_AT_RESET   = 17'd256;

  // Same layout as out_tdata[120:0], status in the lowest bits.
  typedef struct packed {
    logic [52:0] highest_end;
    logic [31:0] reserved_total;
    logic [16:0] free_total;
    logic [15:0] granted;
    logic [2:0]  status;
  } reply_t;

  logic [WORD_BITS-1:0] map_word [MAP_WORDS];
  logic [16:0]          free_cnt;
  logic [31:0]          rsv_cnt;
  logic [52:0]          max_end;
  logic [15:0]          type_mask;
  logic [16:0]          rsv_below;

  reply_t awaited_replies[$];
  reply_t want, got;
  int     bad;

  function automatic void wipe_map();
    foreach (map_word[i]) map_word[i] = '0;
    free_cnt = '0;
    rsv_cnt  = '0;
    max_end  = '0;
  endfunction

  function automatic bit frame_free(input logic [52:0] f);
    return map_word[int'(f >> BIT_W)][f[BIT_W-1:0]];
  endfunction

  // Applies one item to the local map and returns the result it must give.
  function automatic reply_t step_frame_map(input logic [1:0] mode,
                                            input logic [3:0] rtype,
                                            input logic [51:0] start,
                                            input logic [51:0] count,
                                            input logic [51:0] rel);
    reply_t      r;
    logic [52:0] first, stop, hi, rhi, lo, f, limit;
    logic [32:0] sum;
    bit          found;
    r     = '0;
    first = {1'b0, start};
    limit = 53'(rsv_below);
    found = 1'b0;
    r.status = ST_OK;
    case (mode)
      MODE_CLEAR: begin
        wipe_map();
      end
      MODE_REGION: begin
        if (type_mask[rtype]) begin
          stop = first + {1'b0, count};
          if (stop > max_end) max_end = stop;
          hi = (stop < NUM_FRAMES_X) ? stop : NUM_FRAMES_X;
          if (first < hi) begin
            rhi = (hi < limit) ? hi : limit;
            if (first < rhi) begin
              sum     = {1'b0, rsv_cnt} + 33'(rhi - first);
              rsv_cnt = sum[32] ? '1 : sum[31:0];
            end
            lo = (first > limit) ? first : limit;
            for (f = lo; f < hi; f++) begin
              if (!frame_free(f)) begin
                map_word[int'(f >> BIT_W)][f[BIT_W-1:0]] = 1'b1;
                free_cnt++;
              end
            end
          end
        end
      end
      MODE_ALLOC: begin
        r.status = ST_NOFREE;
        for (int w = 0; w < MAP_WORDS && !found; w++) begin
          if (map_word[w] != '0) begin
            for (int b = 0; b < WORD_BITS && !found; b++) begin
              if (map_word[w][b]) begin
                found          = 1'b1;
                map_word[w][b] = 1'b0;
                if (free_cnt != 0) free_cnt--;
                r.granted      = 16'(w * WORD_BITS + b);
                r.status       = ST_OK;
              end
            end
          end
        end
      end
      default: begin
        f = {1'b0, rel};
        if (f == 0) begin
          r.status = ST_ZERO;
        end else if (f >= NUM_FRAMES_X) begin
          r.status = ST_RANGE;
        end else if (frame_free(f)) begin
          r.status = ST_ALREADY;
        end else begin
          map_word[int'(f >> BIT_W)][f[BIT_W-1:0]] = 1'b1;
          free_cnt++;
        end
      end
    endcase
    r.free_total     = free_cnt;
    r.reserved_total = rsv_cnt;
    r.highest_end    = max_end;
    return r;
  endfunction

  function automatic bit field_ok(input string name, input logic [63:0] exp_v,
                                  input logic [63:0] got_v);
    if (exp_v !== got_v)
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v,
               got_v);
    return exp_v === got_v;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      wipe_map();
      type_mask = MASK_AT_RESET;
      rsv_below = RSV_AT_RESET;
      awaited_replies.delete();
      mismatches  <= 0;
      replies_due <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr == ADDR_TYPE_MASK) type_mask = cfg_pwdata[15:0];
        else if (cfg_paddr == ADDR_RSV_BELOW) rsv_below = cfg_pwdata[16:0];
      end
      if (out_tvalid && out_tready) begin
        got = reply_t'(out_tdata[120:0]);
        if (awaited_replies.size() == 0) begin
          $display("%0t: result mismatch, expected no result, got 0x%0h", $time,
                   out_tdata);
          mismatches <= mismatches + 1;
        end else begin
          want = awaited_replies.pop_front();
          bad  = 0;
          bad += !field_ok("status", 64'(want.status), 64'(got.status));
          bad += !field_ok("granted_frame", 64'(want.granted), 64'(got.granted));
          bad += !field_ok("free_total", 64'(want.free_total), 64'(got.free_total));
          bad += !field_ok("reserved_total", 64'(want.reserved_total),
                           64'(got.reserved_total));
          bad += !field_ok("highest_end_frame", 64'(want.highest_end),
                           64'(got.highest_end));
          bad += !field_ok("pad bits", 64'(0), 64'(out_tdata[127:121]));
          if (bad != 0) mismatches <= mismatches + 1;
        end
      end
      if (in_tvalid && in_tready)
        awaited_replies.push_back(step_frame_map(in_tuser, in_tdata[3:0],
                                                 in_tdata[55:4], in_tdata[107:56],
                                                 in_tdata[159:108]));
      replies_due <= awaited_replies.size();
    end
  end

endmodule

@@ sim/tb_bitmap_page_frame_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_page_frame_allocator
// Drives the allocator with a short directed sequence and then with phases
// of random requests under different register settings, with random gaps on
// the item side and random stalls on the result side. The checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_bitmap_page_frame_allocator;
  import bpfa_pkg::*;

  localparam logic [2:0] ADDR_TYPE_MASK = {REG_TYPE_MASK, 2'b00};
  localparam logic [2:0] ADDR_RSV_BELOW = {REG_RSV_BELOW, 2'b00};
  localparam logic [51:0] ALL_ONES_52   = '1;
  // The drain wait covers a full-map region walk, which reads, evaluates
  // and counts every map word, plus stalls.
  localparam int DRAIN_CYCLES = 3 * MAP_WORDS + 64;
  localparam int CYCLE_LIMIT  = 20_000_000;
  localparam int NUM_PHASES   = 8;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // region_type[3:0], region_start_frame[55:4], region_frame_count[107:56],
  // release_frame[159:108]
  logic [159:0] in_tdata = '0;
  // mode[1:0]
  logic [1:0]   in_tuser = MODE_CLEAR;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // status[2:0], granted_frame[18:3], free_total[35:19], reserved_total[67:36],
  // highest_end_frame[120:68], zero[127:121]
  logic [127:0] out_tdata;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  int          mismatches;
  int          replies_due;
  int unsigned cycles = 0;
  bit          calm = 1'b0;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          stall_left = 0;
  int          sent_items = 0;
  logic [15:0] cur_mask = 16'd224;
  logic [16:0] cur_rsv = 17'd256;

  bitmap_page_frame_allocator dut (.*);

  bpfa_checker u_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser, .out_tvalid,
    .out_tready, .out_tdata, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_pready,
    .cfg_paddr, .cfg_pwdata, .mismatches, .replies_due
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: random stall bursts, with the stall rate redrawn
  // periodically so that quiet stretches occur too.
  always @(negedge clk) begin
    if (cycles % 128 == 0) stall_pct = 10 * $urandom_range(0, 4);
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(0, 5);
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic logic [51:0] rand52();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[51:0];
  endfunction

  task automatic send(input logic [1:0] mode, input logic [3:0] rtype,
                      input logic [51:0] start, input logic [51:0] count,
                      input logic [51:0] rel);
    int gap;
    gap = 0;
    if (sent_items % 64 == 0) gap_pct = 15 * $urandom_range(0, 3);
    if (!calm && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 6);
    sent_items++;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {rel, count, start, rtype};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Every item gives one result, so the block is idle once none is awaited.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (replies_due != 0) @(posedge clk);
  endtask

  task automatic set_limits(input logic [15:0] mask, input logic [16:0] rsv);
    write_reg(ADDR_TYPE_MASK, 32'(mask));
    write_reg(ADDR_RSV_BELOW, 32'(rsv));
    cur_mask = mask;
    cur_rsv  = rsv;
  endtask

  task automatic random_request();
    int          pick, shape;
    logic [3:0]  rtype;
    logic [51:0] start, count, rel;
    pick  = $urandom_range(0, 99);
    shape = $urandom_range(0, 99);
    rtype = 4'($urandom_range(0, 15));
    start = rand52();
    count = rand52();
    rel   = rand52();
    if (pick < 2) begin
      send(MODE_CLEAR, rtype, start, count, rel);
    end else if (pick < 26) begin
      // Mostly usable types and small regions in the low part of the map.
      if (cur_mask != 0 && $urandom_range(0, 3) != 0)
        while (!cur_mask[rtype]) rtype = 4'($urandom_range(0, 15));
      if (shape < 80) begin
        start = 52'($urandom_range(0, 4095));
        count = 52'($urandom_range(0, 256));
      end else if (shape < 88) begin
        start = (cur_rsv > 64) ? 52'(cur_rsv) - 52'($urandom_range(0, 64)) : '0;
        count = 52'($urandom_range(1, 128));
      end else if (shape < 93) begin
        start = 52'($urandom_range(0, 65535));
        count = 52'($urandom_range(1, 131072));
      end else if (shape < 95) begin
        start = '0;
        count = 52'(NUM_FRAMES) + 52'($urandom_range(0, 3));
      end
      send(MODE_REGION, rtype, start, count, rel);
    end else if (pick < 60) begin
      send(MODE_ALLOC, rtype, start, count, rel);
    end else if (pick < 97) begin
      if (shape < 80) rel = 52'($urandom_range(0, 1023));
      else if (shape < 90) rel = 52'($urandom_range(0, 65535));
      else if (shape < 95) rel = 52'(NUM_FRAMES) + 52'($urandom_range(0, 65535));
      send(MODE_FREE, rtype, start, count, rel);
    end else begin
      send(2'($urandom_range(0, 3)), rtype, start, count, rel);
    end
  endtask

  initial begin
    logic [15:0] masks  [NUM_PHASES];
    logic [16:0] limits [NUM_PHASES];
    int          counts [NUM_PHASES];
    masks  = '{16'hFFFF, 16'h00E0, 16'h0000, 16'hFFFF, 16'h0000, 16'h0001,
               16'h8421, 16'h00E0};
    limits = '{17'd0, 17'd256, 17'd1024, 17'd65536, 17'd0, 17'd1, 17'd4096,
               17'd256};
    counts = '{250, 250, 60, 60, 250, 150, 200, 180};
    masks[4]  = 16'($urandom_range(1, 65535));
    limits[4] = 17'($urandom_range(0, 65536));

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset register values: types 5 to 7 usable,
    // frames below 256 reserved.
    send(MODE_ALLOC, 4'd0, 52'd0, 52'd0, 52'd0);
    send(MODE_FREE, 4'd0, 52'd0, 52'd0, 52'd0);
    send(MODE_FREE, 4'd0, 52'd0, 52'd0, 52'(NUM_FRAMES));
    send(MODE_FREE, 4'hF, ALL_ONES_52, ALL_ONES_52, ALL_ONES_52);
    send(MODE_REGION, 4'd0, 52'd0, 52'd1000, 52'd0);
    send(MODE_REGION, 4'd7, 52'd0, 52'd300, 52'd0);
    send(MODE_REGION, 4'd6, 52'd200, 52'd120, 52'd0);
    send(MODE_REGION, 4'd5, 52'd65500, 52'd100, 52'd0);
    send(MODE_REGION, 4'd6, ALL_ONES_52, ALL_ONES_52, 52'd0);
    send(MODE_ALLOC, 4'd0, 52'd0, 52'd0, 52'd0);
    send(MODE_FREE, 4'd0, 52'd0, 52'd0, 52'd256);
    send(MODE_FREE, 4'd0, 52'd0, 52'd0, 52'd256);
    send(MODE_FREE, 4'd0, 52'd0, 52'd0, 52'd1);
    send(MODE_ALLOC, 4'd0, 52'd0, 52'd0, 52'd0);
    send(MODE_REGION, 4'd7, 52'd0, 52'd0, 52'd0);
    send(MODE_CLEAR, 4'd0, 52'd0, 52'd0, 52'd0);
    drain();

    // With no reserve limit frame 0 can be handed out.
    set_limits(16'hFFFF, 17'd0);
    send(MODE_REGION, 4'hF, 52'd0, 52'd3, 52'd0);
    send(MODE_ALLOC, 4'd0, 52'd0, 52'd0, 52'd0);
    send(MODE_FREE, 4'd0, 52'd0, 52'd0, 52'd0);
    send(MODE_ALLOC, 4'd0, 52'd0, 52'd0, 52'd0);
    send(MODE_FREE, 4'd0, 52'd0, 52'd0, 52'(NUM_FRAMES - 1));
    send(MODE_ALLOC, 4'd0, 52'd0, 52'd0, 52'd0);
    send(MODE_ALLOC, 4'd0, 52'd0, 52'd0, 52'd0);
    send(MODE_ALLOC, 4'd0, 52'd0, 52'd0, 52'd0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      set_limits(masks[p], limits[p]);
      calm = (p == NUM_PHASES - 1);
      for (int i = 0; i < counts[p]; i++) random_request();
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
